[design/bissc_pkg.sv]
package bissc_pkg;

	localparam int MAX_DATA_BITS = 64;
	localparam int COUNT_WIDTH   = 24;
	localparam int LEN_WIDTH     = 7;
	localparam int POS_WIDTH     = 7;
	localparam int CFG_IDX_WIDTH = 1;

	// frame length: data bits plus two error/warning bits plus six crc bits
	localparam int EW_BITS  = 2;
	localparam int CRC_BITS = 6;
	localparam int SYNC_ZERO_RUN = 14;

	typedef logic [COUNT_WIDTH-1:0]   count_t;
	typedef logic [MAX_DATA_BITS-1:0] data_t;
	typedef logic [LEN_WIDTH-1:0]     len_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_DATA_LENGTH = 1'b0,
		CFG_FRAME_MODE  = 1'b1
	} cfg_index_t;

	// frame mode codes
	localparam logic MODE_REGISTER = 1'b0;
	localparam logic MODE_SENSOR   = 1'b1;

	// event codes
	typedef enum logic [1:0] {
		EV_FRAME_DONE = 2'd0,
		EV_CDS_BIT    = 2'd1,
		EV_CDM_BIT    = 2'd2
	} event_kind_t;

	// one result item
	typedef struct packed {
		event_kind_t          kind;
		data_t                position_data;
		logic [EW_BITS-1:0]   error_warning;
		logic [CRC_BITS-1:0]  frame_crc;
		logic                 bit_value;
		logic                 control_sync;
	} event_t;

	// settings handed from the register file to the frame logic
	typedef struct packed {
		len_t data_length;
		logic frame_mode;
	} cfg_t;

endpackage

[design/bissc_cfg.sv]
module bissc_cfg
	import bissc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [LEN_WIDTH-1:0]     cfg_data,
	output cfg_t                     cfg
);

	len_t data_length_q;
	logic frame_mode_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= len_t'(24);
			frame_mode_q  <= MODE_SENSOR;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_DATA_LENGTH: data_length_q <= cfg_data;
				CFG_FRAME_MODE:  frame_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp length into 1..max data bits
	always_comb begin
		if (data_length_q == '0)
			cfg.data_length = len_t'(1);
		else if (data_length_q > len_t'(MAX_DATA_BITS))
			cfg.data_length = len_t'(MAX_DATA_BITS);
		else
			cfg.data_length = data_length_q;
		cfg.frame_mode = frame_mode_q;
	end

endmodule

[design/bissc_fsm.sv]
module bissc_fsm
	import bissc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   fire,
	input  logic   ma,
	input  logic   slo,
	input  cfg_t   cfg,
	output logic   res_valid,
	output event_t res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ACK     = 3'd1,
		PH_START   = 3'd2,
		PH_ALIGN   = 3'd3,
		PH_CAPTURE = 3'd4,
		PH_GAP     = 3'd5
	} phase_t;

	localparam count_t COUNT_MAX = '1;

	phase_t                 phase_q, phase_d;
	logic [POS_WIDTH-1:0]   bitpos_q, bitpos_d;
	data_t                  data_q, data_d;
	logic [EW_BITS-1:0]     ew_q, ew_d;
	logic [CRC_BITS-1:0]    crc_q, crc_d;
	count_t                 tick_q, tick_d;
	count_t                 limit_q, limit_d;
	logic                   prev_ma_q;
	logic [3:0]             zrun_q, zrun_d;

	logic                   edge_det;
	logic                   falling;
	count_t                 tick_inc;
	logic [COUNT_WIDTH:0]   limit_sum;
	logic [POS_WIDTH:0]     len_ext;
	logic [POS_WIDTH:0]     pos_ext;
	logic                   cdm;

	assign edge_det  = (ma != prev_ma_q);
	assign falling   = edge_det && !ma;
	assign tick_inc  = (tick_q == COUNT_MAX) ? tick_q : tick_q + count_t'(1);
	assign limit_sum = {1'b0, tick_inc} + {2'b0, tick_inc[COUNT_WIDTH-1:1]};
	assign len_ext   = {{(POS_WIDTH + 1 - LEN_WIDTH){1'b0}}, cfg.data_length};
	assign pos_ext   = {1'b0, bitpos_q};
	assign cdm       = ~ma;

	// next-state and result for one line sample
	always_comb begin
		phase_d   = phase_q;
		bitpos_d  = bitpos_q;
		data_d    = data_q;
		ew_d      = ew_q;
		crc_d     = crc_q;
		tick_d    = tick_q;
		limit_d   = limit_q;
		zrun_d    = zrun_q;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = EV_FRAME_DONE;

		case (phase_q)
			PH_IDLE: begin
				if (edge_det && slo) phase_d = PH_ACK;
			end
			PH_ACK: begin
				if (edge_det && !slo) phase_d = PH_START;
			end
			PH_START, PH_ALIGN: begin
				if ((phase_q == PH_START && edge_det && slo && !ma) ||
				    (phase_q == PH_ALIGN && falling)) begin
					phase_d  = PH_CAPTURE;
					bitpos_d = '0;
					data_d   = '0;
					ew_d     = '0;
					crc_d    = '0;
					tick_d   = '0;
				end else if (phase_q == PH_START && edge_det && slo) begin
					phase_d = PH_ALIGN;
				end
			end
			PH_CAPTURE: begin
				tick_d = tick_inc;
				if (falling) begin
					if (bitpos_q == '0) begin
						limit_d = limit_sum[COUNT_WIDTH] ? COUNT_MAX
							: limit_sum[COUNT_WIDTH-1:0];
					end else if (pos_ext <= len_ext) begin
						data_d = {data_q[MAX_DATA_BITS-2:0], slo};
					end else if (pos_ext <= len_ext + (POS_WIDTH+1)'(EW_BITS)) begin
						ew_d = {ew_q[EW_BITS-2:0], slo};
					end else begin
						crc_d = {crc_q[CRC_BITS-2:0], slo};
					end

					// cds bit in register mode, or end of a sensor frame
					if (bitpos_q == '0 && cfg.frame_mode == MODE_REGISTER) begin
						res_valid     = 1'b1;
						res.kind      = EV_CDS_BIT;
						res.bit_value = slo;
						phase_d       = PH_GAP;
						tick_d        = '0;
					end else if (pos_ext >=
						len_ext + (POS_WIDTH+1)'(EW_BITS + CRC_BITS)) begin
						res_valid         = 1'b1;
						res.kind          = EV_FRAME_DONE;
						res.position_data = data_d;
						res.error_warning = ew_d;
						res.frame_crc     = crc_d;
						phase_d           = PH_GAP;
						tick_d            = '0;
					end else begin
						bitpos_d = bitpos_q + POS_WIDTH'(1);
					end
				end
			end
			PH_GAP: begin
				if (edge_det) begin
					if (tick_inc < limit_q) tick_d = '0;
					else phase_d = PH_IDLE;
				end else begin
					tick_d = tick_inc;
					if (tick_inc > limit_q) begin
						phase_d = PH_IDLE;
						if (cfg.frame_mode == MODE_REGISTER) begin
							if (cdm) zrun_d = '0;
							else if (zrun_q != 4'hF) zrun_d = zrun_q + 4'd1;
							res_valid        = 1'b1;
							res.kind         = EV_CDM_BIT;
							res.bit_value    = cdm;
							res.control_sync = (zrun_d >= 4'(SYNC_ZERO_RUN));
						end
					end
				end
			end
			default: begin
				// unused codes behave as hunting for idle high
				if (edge_det && slo) phase_d = PH_ACK;
				else phase_d = PH_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bitpos_q  <= '0;
			data_q    <= '0;
			ew_q      <= '0;
			crc_q     <= '0;
			tick_q    <= '0;
			limit_q   <= '0;
			prev_ma_q <= 1'b1;
			zrun_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			bitpos_q  <= bitpos_d;
			data_q    <= data_d;
			ew_q      <= ew_d;
			crc_q     <= crc_d;
			tick_q    <= tick_d;
			limit_q   <= limit_d;
			prev_ma_q <= ma;
			zrun_q    <= zrun_d;
		end
	end

endmodule

[design/bissc_frame_receiver.sv]
// A line sample accepted into the input register has its event, if any, loaded
// into the result register when the frame logic fires; a held event can delay that.
// Throughput: one sample per cycle while no held event stalls the input.
// A held event stalls the input only once the input register is also full.
// Reset (arst_n low, asynchronous) hunts for idle high, data_length 24, sensor mode.
module bissc_frame_receiver
	import bissc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// line samples
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic                     ma_level,
	input  logic                     slo_level,
	// events
	output logic                     event_valid,
	input  logic                     event_stall,
	output logic [1:0]               event_kind,
	output logic [MAX_DATA_BITS-1:0] position_data,
	output logic [EW_BITS-1:0]       error_warning,
	output logic [CRC_BITS-1:0]      frame_crc,
	output logic                     bit_value,
	output logic                     control_sync,
	// configuration writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [LEN_WIDTH-1:0]     cfg_data
);

	logic   valid_s1;
	logic   ma_s1;
	logic   slo_s1;
	logic   fire;
	logic   accept;
	logic   res_valid;
	event_t res;
	event_t event_q;
	logic   event_valid_q;
	cfg_t   cfg;

	assign cfg_ready    = 1'b1;
	assign fire         = valid_s1 && (!event_valid_q || !event_stall);
	assign sample_stall = valid_s1 && !fire;
	assign accept       = sample_valid && !sample_stall;

	bissc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ma_s1  <= ma_level;
			slo_s1 <= slo_level;
		end
	end

	bissc_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.ma        (ma_s1),
		.slo       (slo_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_q <= 1'b0;
		end else if (fire) begin
			event_valid_q <= res_valid;
		end else if (!event_stall) begin
			event_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) event_q <= res;
	end

	assign event_valid   = event_valid_q;
	assign event_kind    = event_q.kind;
	assign position_data = event_q.position_data;
	assign error_warning = event_q.error_warning;
	assign frame_crc     = event_q.frame_crc;
	assign bit_value     = event_q.bit_value;
	assign control_sync  = event_q.control_sync;

endmodule
